>>> sv/lfuc_pkg.sv
`default_nettype none

package lfuc_pkg;

  localparam int CAPACITY = 10;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = CNT_W + 1;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 64;
  localparam int USES_W   = 32;
  localparam int STATUS_W = 2;
  localparam int UPC_W    = 5;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEL_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [USES_W-1:0] uses;
  } lfuc_entry_t;

  localparam int ENTRY_W = $bits(lfuc_entry_t);

  typedef enum logic [1:0] {RD_NONE, RD_PTR, RD_PTR_M1, RD_PTR_P1} lfuc_rd_t;
  typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_NEW, WR_BUMP} lfuc_wr_t;
  typedef enum logic [2:0] {PTR_HOLD, PTR_OCC, PTR_CLR, PTR_INC, PTR_DEC} lfuc_ptr_t;
  typedef enum logic [1:0] {OCC_HOLD, OCC_INC, OCC_DEC} lfuc_occ_t;
  typedef enum logic [2:0] {
    RES_NONE, RES_DONE, RES_MISS, RES_DEL_MISS, RES_EVICT, RES_HIT
  } lfuc_res_t;
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_OCC_FULL, C_OCC_ZERO, C_PTR_ZERO, C_PTR_GT1,
    C_KEY_MATCH, C_NEXT_LT_OCC, C_NEXT_GE_OCC, C_NEXT2_LT_OCC
  } lfuc_cond_t;

  typedef struct packed {
    lfuc_rd_t          rd;
    lfuc_wr_t          wr;
    lfuc_ptr_t         ptr;
    lfuc_occ_t         occ;
    lfuc_res_t         res;
    lfuc_cond_t        cond;
    logic              last;
    logic [UPC_W-1:0]  target;
  } lfuc_uop_t;

  typedef struct packed {
    logic occ_full;
    logic occ_zero;
    logic ptr_zero;
    logic ptr_gt1;
    logic key_match;
    logic next_lt_occ;
    logic next2_lt_occ;
    logic out_free;
  } lfuc_flags_t;

  // program labels
  localparam logic [UPC_W-1:0] U_EMIT  = 5'd0;
  localparam logic [UPC_W-1:0] U_NOP   = 5'd1;
  localparam logic [UPC_W-1:0] U_A0    = 5'd2;
  localparam logic [UPC_W-1:0] U_A1    = 5'd3;
  localparam logic [UPC_W-1:0] U_A2R   = 5'd4;
  localparam logic [UPC_W-1:0] U_A2W   = 5'd5;
  localparam logic [UPC_W-1:0] U_A3    = 5'd6;
  localparam logic [UPC_W-1:0] U_AF    = 5'd7;
  localparam logic [UPC_W-1:0] U_F0    = 5'd8;
  localparam logic [UPC_W-1:0] U_F1    = 5'd9;
  localparam logic [UPC_W-1:0] U_F2    = 5'd10;
  localparam logic [UPC_W-1:0] U_F3    = 5'd11;
  localparam logic [UPC_W-1:0] U_FMISS = 5'd12;
  localparam logic [UPC_W-1:0] U_FHIT  = 5'd13;
  localparam logic [UPC_W-1:0] U_D0    = 5'd14;
  localparam logic [UPC_W-1:0] U_D1    = 5'd15;
  localparam logic [UPC_W-1:0] U_D2    = 5'd16;
  localparam logic [UPC_W-1:0] U_D3    = 5'd17;
  localparam logic [UPC_W-1:0] U_DMISS = 5'd18;
  localparam logic [UPC_W-1:0] U_DSH   = 5'd19;
  localparam logic [UPC_W-1:0] U_DR    = 5'd20;
  localparam logic [UPC_W-1:0] U_DW    = 5'd21;
  localparam logic [UPC_W-1:0] U_DEND  = 5'd22;

  localparam lfuc_uop_t UOP_IDLE = '{
    rd: RD_NONE, wr: WR_NONE, ptr: PTR_HOLD, occ: OCC_HOLD, res: RES_NONE,
    cond: C_NEVER, last: 1'b0, target: U_EMIT
  };

  function automatic lfuc_uop_t lfuc_mk(
    input lfuc_rd_t rd, input lfuc_wr_t wr, input lfuc_ptr_t ptr,
    input lfuc_occ_t occ, input lfuc_res_t res, input lfuc_cond_t cond,
    input logic last, input logic [UPC_W-1:0] target
  );
    lfuc_uop_t u;
    u.rd     = rd;
    u.wr     = wr;
    u.ptr    = ptr;
    u.occ    = occ;
    u.res    = res;
    u.cond   = cond;
    u.last   = last;
    u.target = target;
    return u;
  endfunction

  function automatic lfuc_uop_t lfuc_rom(input logic [UPC_W-1:0] upc);
    lfuc_uop_t u;
    case (upc)
      U_EMIT:  u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_NEVER, 1'b1, U_EMIT);
      U_NOP:   u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_DONE,
                           C_ALWAYS, 1'b0, U_EMIT);
      // add: open a hole at the head, shifting entries down one slot
      U_A0:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_OCC, OCC_HOLD, RES_NONE,
                           C_OCC_FULL, 1'b0, U_AF);
      U_A1:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_PTR_ZERO, 1'b0, U_A3);
      U_A2R:   u = lfuc_mk(RD_PTR_M1, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_NEVER, 1'b0, U_EMIT);
      U_A2W:   u = lfuc_mk(RD_NONE, WR_SHIFT, PTR_DEC, OCC_HOLD, RES_NONE,
                           C_PTR_GT1, 1'b0, U_A2R);
      U_A3:    u = lfuc_mk(RD_NONE, WR_NEW, PTR_HOLD, OCC_INC, RES_DONE,
                           C_ALWAYS, 1'b0, U_EMIT);
      // full table: new entry has the lowest count and goes first
      U_AF:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_EVICT,
                           C_ALWAYS, 1'b0, U_EMIT);
      // find: scan from the head
      U_F0:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_CLR, OCC_HOLD, RES_NONE,
                           C_OCC_ZERO, 1'b0, U_FMISS);
      U_F1:    u = lfuc_mk(RD_PTR, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_NEVER, 1'b0, U_EMIT);
      U_F2:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_KEY_MATCH, 1'b0, U_FHIT);
      U_F3:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_INC, OCC_HOLD, RES_NONE,
                           C_NEXT_LT_OCC, 1'b0, U_F1);
      U_FMISS: u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_MISS,
                           C_ALWAYS, 1'b0, U_EMIT);
      U_FHIT:  u = lfuc_mk(RD_NONE, WR_BUMP, PTR_HOLD, OCC_HOLD, RES_HIT,
                           C_ALWAYS, 1'b0, U_EMIT);
      // delete: scan, then close the gap
      U_D0:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_CLR, OCC_HOLD, RES_NONE,
                           C_OCC_ZERO, 1'b0, U_DMISS);
      U_D1:    u = lfuc_mk(RD_PTR, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_NEVER, 1'b0, U_EMIT);
      U_D2:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_KEY_MATCH, 1'b0, U_DSH);
      U_D3:    u = lfuc_mk(RD_NONE, WR_NONE, PTR_INC, OCC_HOLD, RES_NONE,
                           C_NEXT_LT_OCC, 1'b0, U_D1);
      U_DMISS: u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_DEL_MISS,
                           C_ALWAYS, 1'b0, U_EMIT);
      U_DSH:   u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_NEXT_GE_OCC, 1'b0, U_DEND);
      U_DR:    u = lfuc_mk(RD_PTR_P1, WR_NONE, PTR_HOLD, OCC_HOLD, RES_NONE,
                           C_NEVER, 1'b0, U_EMIT);
      U_DW:    u = lfuc_mk(RD_NONE, WR_SHIFT, PTR_INC, OCC_HOLD, RES_NONE,
                           C_NEXT2_LT_OCC, 1'b0, U_DR);
      U_DEND:  u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_DEC, RES_DONE,
                           C_ALWAYS, 1'b0, U_EMIT);
      default: u = lfuc_mk(RD_NONE, WR_NONE, PTR_HOLD, OCC_HOLD, RES_DONE,
                           C_ALWAYS, 1'b0, U_EMIT);
    endcase
    return u;
  endfunction

  function automatic logic [UPC_W-1:0] lfuc_entry_pc(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] pc;
    case (op)
      OP_ADD:  pc = U_A0;
      OP_FIND: pc = U_F0;
      OP_DEL:  pc = U_D0;
      default: pc = U_NOP;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

>>> sv/lfuc_ram.sv
`default_nettype none

module lfuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/lfuc_seq.sv
`default_nettype none

module lfuc_seq import lfuc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   op,
  input  wire lfuc_flags_t       flags,
  output logic                   busy,
  output lfuc_uop_t              uop,
  output logic                   emit
);

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             take;

  always_comb begin
    uop = busy_r ? lfuc_rom(upc_r) : UOP_IDLE;
    case (uop.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_OCC_FULL:     take = flags.occ_full;
      C_OCC_ZERO:     take = flags.occ_zero;
      C_PTR_ZERO:     take = flags.ptr_zero;
      C_PTR_GT1:      take = flags.ptr_gt1;
      C_KEY_MATCH:    take = flags.key_match;
      C_NEXT_LT_OCC:  take = flags.next_lt_occ;
      C_NEXT_GE_OCC:  take = !flags.next_lt_occ;
      C_NEXT2_LT_OCC: take = flags.next2_lt_occ;
      default:        take = 1'b0;
    endcase
  end

  assign emit = busy_r && uop.last && flags.out_free;
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = lfuc_entry_pc(op);
      end
    end else if (uop.last) begin
      // wait here until the output register frees up
      if (flags.out_free) begin
        busy_nxt = 1'b0;
      end
    end else if (take) begin
      upc_nxt = uop.target;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= U_EMIT;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/lfu_object_cache_top.sv
`default_nettype none

// Small LFU-style keyed cache of CAPACITY entries (key, 64-bit data, use count), newest
// first. A command beat is taken whenever no command is in progress; its result beat lands
// in an output register, so a new command may start while that result waits. Commands run
// one at a time under a microcoded sequencer over a single-port-read entry RAM with
// registered read: each entry scanned takes a read, a key compare and a pointer step, and
// each entry moved takes a read and a write. The final step of a command waits while the
// output register still holds a result that out_ready has not yet taken, and the next
// command beat is taken only once the sequencer has gone idle.

module lfu_object_cache_top import lfuc_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [OP_W-1:0]     in_op,
  input  wire logic signed [KEY_W-1:0]    in_key,
  input  wire logic        [DATA_W-1:0]   in_payload,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [STATUS_W-1:0] out_status,
  output logic             [DATA_W-1:0]   out_data_out,
  output logic signed      [KEY_W-1:0]    out_evicted_key
);

  logic               start;
  logic               busy;
  logic               emit;
  lfuc_uop_t          uop;
  lfuc_flags_t        flags;

  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [DATA_W-1:0]  payload_r, payload_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;

  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [DATA_W-1:0]      res_data_r, res_data_nxt;
  logic signed [KEY_W-1:0] res_evk_r, res_evk_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [DATA_W-1:0]       out_data_r, out_data_nxt;
  logic signed [KEY_W-1:0] out_evk_r, out_evk_nxt;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [ENTRY_W-1:0] rd_data;
  lfuc_entry_t        rd_entry, wr_entry;
  logic [CMP_W-1:0]   ptr_ext, occ_ext;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  lfuc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .flags (flags),
    .busy  (busy),
    .uop   (uop),
    .emit  (emit)
  );

  lfuc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_entry = lfuc_entry_t'(rd_data);
  assign ptr_ext  = CMP_W'(ptr_r);
  assign occ_ext  = CMP_W'(occ_r);

  always_comb begin
    flags.occ_full     = (occ_r == CNT_W'(CAPACITY));
    flags.occ_zero     = (occ_r == '0);
    flags.ptr_zero     = (ptr_r == '0);
    flags.ptr_gt1      = (ptr_ext > CMP_W'(1));
    flags.key_match    = (rd_entry.key == key_r);
    flags.next_lt_occ  = ((ptr_ext + CMP_W'(1)) < occ_ext);
    flags.next2_lt_occ = ((ptr_ext + CMP_W'(2)) < occ_ext);
    flags.out_free     = !out_valid_r || out_ready;
  end

  // entry ram access
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r;
    case (uop.rd)
      RD_PTR:    rd_en = 1'b1;
      RD_PTR_M1: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r - IDX_W'(1);
      end
      RD_PTR_P1: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r + IDX_W'(1);
      end
      default:   rd_en = 1'b0;
    endcase

    wr_en    = 1'b0;
    wr_addr  = ptr_r;
    wr_entry = rd_entry;
    case (uop.wr)
      WR_SHIFT: wr_en = 1'b1;
      WR_NEW: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_entry.key  = key_r;
        wr_entry.data = payload_r;
        wr_entry.uses = '0;
      end
      WR_BUMP: begin
        wr_en = 1'b1;
        if (rd_entry.uses != '1) begin
          wr_entry.uses = rd_entry.uses + USES_W'(1);
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (start) begin
      key_nxt     = in_key;
      payload_nxt = in_payload;
    end

    case (uop.ptr)
      PTR_OCC: ptr_nxt = IDX_W'(occ_r);
      PTR_CLR: ptr_nxt = '0;
      PTR_INC: ptr_nxt = ptr_r + IDX_W'(1);
      PTR_DEC: ptr_nxt = ptr_r - IDX_W'(1);
      default: ptr_nxt = ptr_r;
    endcase

    case (uop.occ)
      OCC_INC: occ_nxt = occ_r + CNT_W'(1);
      OCC_DEC: occ_nxt = occ_r - CNT_W'(1);
      default: occ_nxt = occ_r;
    endcase

    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_evk_nxt    = res_evk_r;
    case (uop.res)
      RES_DONE: begin
        res_status_nxt = ST_DONE;
        res_data_nxt   = '0;
        res_evk_nxt    = '0;
      end
      RES_MISS: begin
        res_status_nxt = ST_MISS;
        res_data_nxt   = '0;
        res_evk_nxt    = '0;
      end
      RES_DEL_MISS: begin
        res_status_nxt = ST_DEL_MISS;
        res_data_nxt   = '0;
        res_evk_nxt    = '0;
      end
      RES_EVICT: begin
        res_status_nxt = ST_EVICT;
        res_data_nxt   = '0;
        res_evk_nxt    = key_r;
      end
      RES_HIT: begin
        res_status_nxt = ST_DONE;
        res_data_nxt   = rd_entry.data;
        res_evk_nxt    = '0;
      end
      default: res_status_nxt = res_status_r;
    endcase

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_evk_nxt    = out_evk_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_data_nxt   = res_data_r;
      out_evk_nxt    = res_evk_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    payload_r    <= payload_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_evk_r    <= res_evk_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_evk_r    <= out_evk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_evicted_key = out_evk_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res_status_r == ST_EVICT) |-> flags.occ_full)
    else $error("eviction reported on a table that is not full");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CMP_W'(wr_addr) <= occ_ext))
    else $error("entry write beyond the occupied region");

  a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid && !busy))
    else $error("result beat not presented after the last step");
`endif

endmodule

`default_nettype wire

>>> bench/lfu_object_cache_top_tb.sv
`default_nettype none

module lfu_object_cache_top_tb;
  import lfuc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_CMDS = 1825;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 20;

  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALL, PACE_BOTH} pace_t;
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [KEY_W-1:0]  key;
    logic [DATA_W-1:0]        payload;
    pace_t                    pace;
  } cmd_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [DATA_W-1:0]        data;
    logic signed [KEY_W-1:0]  evk;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [DATA_W-1:0] in_payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0] out_data_out;
  logic signed [KEY_W-1:0] out_evicted_key;

  lfu_object_cache_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_evicted_key (out_evicted_key)
  );

  always #5 clk = ~clk;

  // shadow copy of the cache contents, slot 0 newest
  logic [KEY_W-1:0]  tbl_key  [CAPACITY];
  logic [DATA_W-1:0] tbl_data [CAPACITY];
  logic [USES_W-1:0] tbl_uses [CAPACITY];
  int occ = 0;

  cmd_t cmd_q[$];
  outcome_t result_q[$];
  cmd_t cur;
  pace_t rx_pace = PACE_FULL;
  int total_cmds = 0;
  int accepted = 0;
  int results_seen = 0;
  int fails = 0;
  int cycles = 0;
  int status_tally [4] = '{0, 0, 0, 0};
  int find_hits = 0;

  function automatic outcome_t cache_apply(input cmd_t c);
    outcome_t r;
    int hit;
    r.status = ST_DONE;
    r.data = '0;
    r.evk = '0;
    hit = -1;
    for (int i = occ - 1; i >= 0; i--)
      if (tbl_key[i] == c.key) hit = i;
    case (c.op)
      OP_ADD: begin
        if (occ >= CAPACITY) begin
          // fresh entry has the lowest count and stands first, so it goes
          r.status = ST_EVICT;
          r.evk = c.key;
        end else begin
          for (int i = occ; i > 0; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_data[i] = tbl_data[i-1];
            tbl_uses[i] = tbl_uses[i-1];
          end
          tbl_key[0] = c.key;
          tbl_data[0] = c.payload;
          tbl_uses[0] = '0;
          occ++;
        end
      end
      OP_FIND: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          if (tbl_uses[hit] != '1) tbl_uses[hit] = tbl_uses[hit] + 1'b1;
          r.data = tbl_data[hit];
        end
      end
      OP_DEL: begin
        if (hit < 0) begin
          r.status = ST_DEL_MISS;
        end else begin
          for (int i = hit; i < occ - 1; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_data[i] = tbl_data[i+1];
            tbl_uses[i] = tbl_uses[i+1];
          end
          occ--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int send_gap_pct(input pace_t p);
    case (p)
      PACE_SEND_GAPS: return 66;
      PACE_BOTH:      return 29;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input pace_t p);
    case (p)
      PACE_RECV_STALL: return 66;
      PACE_BOTH:       return 29;
      default:         return 0;
    endcase
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [DATA_W-1:0] payload, input pace_t pace);
    cmd_t c;
    c.op = op;
    c.key = key;
    c.payload = payload;
    c.pace = pace;
    cmd_q.push_back(c);
  endtask

  // driver
  always @(posedge clk) begin : drive
    outcome_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = cache_apply(cur);
        result_q.push_back(want);
        status_tally[want.status]++;
        if (cur.op == OP_FIND && want.status == ST_DONE) find_hits++;
        rx_pace <= cur.pace;
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_gap_pct(cmd_q[0].pace)) begin
          cur = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_op <= cur.op;
          in_key <= cur.key;
          in_payload <= cur.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result beat: status %0d data %h evicted %h",
                     out_status, out_data_out, out_evicted_key);
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status || out_data_out !== want.data ||
              out_evicted_key !== want.evk) begin
            fails++;
            if (fails <= 10)
              $display("mismatch on result %0d: status %0d/%0d data %h/%h evicted %h/%h",
                       results_seen, want.status, out_status, want.data, out_data_out,
                       want.evk, out_evicted_key);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct(rx_pace));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] pool [12];
    logic [KEY_W-1:0] k;
    logic [DATA_W-1:0] pl;
    logic [OP_W-1:0] op;
    mix_t mix;
    pace_t pace;
    int r;

    // empty table, unused code, extremes, duplicates, fill to full, evict
    push_cmd(OP_FIND, 32'd5, '0, PACE_FULL);
    push_cmd(OP_DEL, 32'd5, '0, PACE_FULL);
    push_cmd(OP_UNUSED, 32'hffff_ffff, '1, PACE_FULL);
    push_cmd(OP_ADD, 32'h8000_0000, '0, PACE_FULL);
    push_cmd(OP_ADD, 32'h7fff_ffff, '1, PACE_FULL);
    push_cmd(OP_ADD, 32'h0000_0000, 64'h0123_4567_89ab_cdef, PACE_FULL);
    push_cmd(OP_ADD, 32'hffff_ffff, 64'hfedc_ba98_7654_3210, PACE_FULL);
    push_cmd(OP_FIND, 32'h8000_0000, '1, PACE_FULL);
    push_cmd(OP_FIND, 32'h7fff_ffff, '0, PACE_FULL);
    push_cmd(OP_ADD, 32'h7fff_ffff, 64'haaaa_5555_aaaa_5555, PACE_FULL);
    push_cmd(OP_FIND, 32'h7fff_ffff, '0, PACE_FULL);
    push_cmd(OP_DEL, 32'h7fff_ffff, '0, PACE_FULL);
    push_cmd(OP_FIND, 32'h7fff_ffff, '0, PACE_FULL);
    push_cmd(OP_DEL, 32'd12345, '0, PACE_FULL);
    for (int i = 0; i < 6; i++)
      push_cmd(OP_ADD, 32'd100 + i, {$urandom, $urandom}, PACE_FULL);
    push_cmd(OP_ADD, 32'd77, 64'h5555_aaaa_5555_aaaa, PACE_FULL);
    push_cmd(OP_FIND, 32'd77, '0, PACE_FULL);
    push_cmd(OP_FIND, 32'h8000_0000, '0, PACE_FULL);
    push_cmd(OP_DEL, 32'h8000_0000, '0, PACE_FULL);
    push_cmd(OP_ADD, 32'd77, 64'h1, PACE_FULL);

    // small key pool so finds and deletes hit and duplicates build up
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 12; i++) pool[i] = $urandom;

    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 40 == 0) mix = mix_t'($urandom_range(2));
      pace = pace_t'((n / 120) % 4);
      r = $urandom_range(99);
      if (r < 2) op = OP_UNUSED;
      else if (mix == MIX_FILL) op = (r < 60) ? OP_ADD : (r < 88) ? OP_FIND : OP_DEL;
      else if (mix == MIX_CHURN) op = (r < 32) ? OP_ADD : (r < 75) ? OP_FIND : OP_DEL;
      else op = (r < 12) ? OP_ADD : (r < 42) ? OP_FIND : OP_DEL;
      k = ($urandom_range(99) < 75) ? pool[$urandom_range(11)] : $urandom;
      r = $urandom_range(19);
      pl = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      push_cmd(op, k, pl, pace);
    end
    total_cmds = cmd_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_cmds) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (result_q.size() != 0) begin
      fails += result_q.size();
      $display("%0d expected results never arrived", result_q.size());
    end
    $display("ran %0d commands over four pacing modes: %0d find hits, %0d find misses,",
             accepted, find_hits, status_tally[ST_MISS]);
    $display("  %0d delete misses, %0d full-table evictions, %0d mismatches in %0d cycles",
             status_tally[ST_DEL_MISS], status_tally[ST_EVICT], fails, cycles);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
